@@ rtl/core/scia_pkg.sv @@
// Shared types and constants for the size-class ID allocator.
// No dependencies; every other file of the block but scia_mem imports this package.
`default_nettype none

package scia_pkg;

    // Default sizing, handed to the top level parameters.
    localparam int DEF_NUM_CLASSES = 8;
    localparam int DEF_STACK_DEPTH = 16;
    localparam int DEF_ID_BITS     = 16;

    // Fixed field widths of the request and response items.
    localparam int RUN_W = 4;
    localparam int ID_W  = 16;

    // Request function codes.
    localparam logic FUNC_FREE  = 1'b0;
    localparam logic FUNC_ALLOC = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_SIZE  = 2'd1,
        ST_FULL      = 2'd2,
        ST_EXHAUSTED = 2'd3
    } status_t;

    // Decision made for one item, carried from the control logic to the
    // result register. The stack read data, registered in the memory, joins it at the output.
    typedef struct packed {
        status_t          status;
        logic             from_free;
        logic [ID_W-1:0]  bump_base;
    } result_meta_t;

endpackage

`default_nettype wire

@@ rtl/core/scia_req_if.sv @@
// Request channel of the size-class ID allocator: valid/ready plus payload.
// Depends on scia_pkg for field widths.
`default_nettype none

interface scia_req_if;
    import scia_pkg::*;

    logic              valid;
    logic              ready;
    logic              func;
    logic [RUN_W-1:0]  run_size;
    logic [ID_W-1:0]   freed_base;

    modport source (output valid, output func, output run_size, output freed_base,
                    input ready);
    modport sink   (input valid, input func, input run_size, input freed_base,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/core/scia_rsp_if.sv @@
// Response channel of the size-class ID allocator: valid/ready plus payload.
// Depends on scia_pkg for field widths and the status type.
`default_nettype none

interface scia_rsp_if;
    import scia_pkg::*;

    logic             valid;
    logic             ready;
    logic [ID_W-1:0]  base_id;
    logic             from_free_list;
    status_t          status;

    modport source (output valid, output base_id, output from_free_list, output status,
                    input ready);
    modport sink   (input valid, input base_id, input from_free_list, input status,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/core/scia_mem.sv @@
// Free stack storage: one memory holding every class's stack, one access
// per cycle, registered read data. Depends on nothing but its parameters.
`default_nettype none

module scia_mem #(
    parameter int DEPTH = 128,
    parameter int AW    = 7,
    parameter int DW    = 16
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] addr,
    input  wire logic [DW-1:0] wdata,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/core/scia_ctrl.sv @@
// Allocation decision: per-class fill counts, bump pointer, status, and the
// stack memory access for one item. Depends on scia_pkg.
`default_nettype none

module scia_ctrl #(
    parameter int NUM_CLASSES = 8,
    parameter int STACK_DEPTH = 16,
    parameter int ID_BITS     = 16,
    parameter int MEM_AW      = 7,
    parameter int SW          = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         fire,
    input  wire logic                         func,
    input  wire logic [scia_pkg::RUN_W-1:0]   run_size,
    input  wire logic [scia_pkg::ID_W-1:0]    freed_base,
    output scia_pkg::result_meta_t            meta,
    output logic                              mem_wr_en,
    output logic                              mem_rd_en,
    output logic      [MEM_AW-1:0]            mem_addr,
    output logic      [SW-1:0]                mem_wdata
);
    import scia_pkg::*;

    localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int FILL_W = $clog2(STACK_DEPTH + 1);
    localparam int NB_W   = ID_BITS + 1;
    localparam int SUM_W  = ID_BITS + 2;

    logic [FILL_W-1:0] fill_reg  [NUM_CLASSES];
    logic [FILL_W-1:0] fill_next [NUM_CLASSES];
    logic [NB_W-1:0]   next_base_reg;
    logic [NB_W-1:0]   next_base_next;

    logic              size_ok;
    logic [CLS_W-1:0]  cls;
    logic [FILL_W-1:0] fill;
    logic              stack_full;
    logic              stack_empty;
    logic [FILL_W-1:0] slot;
    logic [SUM_W-1:0]  bump_sum;
    logic              exhausted;
    logic [31:0]       bump_wide;

    assign size_ok     = (run_size != '0) && (run_size <= RUN_W'(NUM_CLASSES));
    assign cls         = CLS_W'(run_size - RUN_W'(1));
    assign fill        = fill_reg[cls];
    assign stack_full  = (fill == FILL_W'(STACK_DEPTH));
    assign stack_empty = (fill == '0);
    assign slot        = (func == FUNC_ALLOC) ? (fill - FILL_W'(1)) : fill;

    // The pointer never passes 2^ID_BITS, so the sum fits with room to spare.
    assign bump_sum  = SUM_W'(next_base_reg) + SUM_W'(run_size);
    assign exhausted = bump_sum > (SUM_W'(1) << ID_BITS);
    assign bump_wide = 32'(next_base_reg[ID_BITS-1:0]);

    assign mem_addr  = MEM_AW'(32'(cls) * STACK_DEPTH) + MEM_AW'(slot);
    assign mem_wdata = freed_base[SW-1:0];

    always_comb
    begin
        meta           = '{status: ST_OK, from_free: 1'b0, bump_base: '0};
        mem_wr_en      = 1'b0;
        mem_rd_en      = 1'b0;
        fill_next      = fill_reg;
        next_base_next = next_base_reg;
        if (!size_ok)
        begin
            meta.status = ST_BAD_SIZE;
        end
        else if (func == FUNC_FREE)
        begin
            if (stack_full)
            begin
                meta.status = ST_FULL;
            end
            else
            begin
                mem_wr_en      = fire;
                fill_next[cls] = fill + FILL_W'(1);
            end
        end
        else if (!stack_empty)
        begin
            meta.from_free = 1'b1;
            mem_rd_en      = fire;
            fill_next[cls] = slot;
        end
        else if (exhausted)
        begin
            meta.status = ST_EXHAUSTED;
        end
        else
        begin
            meta.bump_base = bump_wide[ID_W-1:0];
            next_base_next = bump_sum[NB_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                fill_reg[i] <= '0;
            end
            next_base_reg <= '0;
        end
        else if (fire)
        begin
            fill_reg      <= fill_next;
            next_base_reg <= next_base_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/size_class_id_allocator.sv @@
// Top level of the size-class ID allocator: input register, decision logic,
// stack memory and result register. Depends on scia_pkg, scia_req_if,
// scia_rsp_if, scia_ctrl and scia_mem.
//
//   Channel  Dir  Fields
//   req      in   func, run_size, freed_base
//   rsp      out  base_id, from_free_list, status
//
// One item per cycle is accepted while rsp is not stalled. An accepted item waits in
// the input register; the result register and the registered stack memory read are
// loaded together when it is processed, and the result is then offered on rsp.
// The single memory port and the fill count of the class are touched once per
// item, which is what sets the one-item-per-cycle rate.
// Reset clears the fill counts and the bump pointer; the stack memory is not
// cleared. When rsp is stalled the result register holds, the input register
// fills, and req.ready drops.
`default_nettype none

module size_class_id_allocator #(
    parameter int NUM_CLASSES = scia_pkg::DEF_NUM_CLASSES,
    parameter int STACK_DEPTH = scia_pkg::DEF_STACK_DEPTH,
    parameter int ID_BITS     = scia_pkg::DEF_ID_BITS
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    scia_req_if.sink    req,
    scia_rsp_if.source  rsp
);
    import scia_pkg::*;

    localparam int MEM_DEPTH = NUM_CLASSES * STACK_DEPTH;
    localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int SW        = (ID_BITS < ID_W) ? ID_BITS : ID_W;

    logic              in_valid_reg;
    logic              func_reg;
    logic [RUN_W-1:0]  run_size_reg;
    logic [ID_W-1:0]   freed_base_reg;

    logic              out_valid_reg;
    result_meta_t      meta_reg;
    result_meta_t      meta;

    logic              advance;
    logic              fire;
    logic              mem_wr_en;
    logic              mem_rd_en;
    logic [MEM_AW-1:0] mem_addr;
    logic [SW-1:0]     mem_wdata;
    logic [SW-1:0]     mem_rdata;

    assign advance   = !out_valid_reg || rsp.ready;
    assign fire      = in_valid_reg && advance;
    assign req.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            func_reg       <= req.func;
            run_size_reg   <= req.run_size;
            freed_base_reg <= req.freed_base;
        end
        if (fire)
        begin
            meta_reg <= meta;
        end
    end

    scia_ctrl #(
        .NUM_CLASSES (NUM_CLASSES),
        .STACK_DEPTH (STACK_DEPTH),
        .ID_BITS     (ID_BITS),
        .MEM_AW      (MEM_AW),
        .SW          (SW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .func       (func_reg),
        .run_size   (run_size_reg),
        .freed_base (freed_base_reg),
        .meta       (meta),
        .mem_wr_en  (mem_wr_en),
        .mem_rd_en  (mem_rd_en),
        .mem_addr   (mem_addr),
        .mem_wdata  (mem_wdata)
    );

    scia_mem #(
        .DEPTH (MEM_DEPTH),
        .AW    (MEM_AW),
        .DW    (SW)
    ) u_mem (
        .clk   (clk),
        .wr_en (mem_wr_en),
        .rd_en (mem_rd_en),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // A reused base comes straight from the registered memory read.
    assign rsp.valid          = out_valid_reg;
    assign rsp.base_id        = meta_reg.from_free ? ID_W'(mem_rdata) : meta_reg.bump_base;
    assign rsp.from_free_list = meta_reg.from_free;
    assign rsp.status         = meta_reg.status;

`ifndef SYNTH
    a_one_mem_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_wr_en && mem_rd_en))
        else $error("stack memory read and write in the same cycle");

    a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("processed item did not reach the result register");

    a_reuse_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.from_free_list) |-> (rsp.status == ST_OK))
        else $error("reused base reported with a failing status");

    a_fail_zero_base: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status != ST_OK)) |-> (rsp.base_id == '0))
        else $error("nonzero base with a failing status");
`endif

endmodule

`default_nettype wire
